// ----- rtl/core/lfu_cache_lru_tiebreak_core_defines.svh -----
// ----------------------------------------------------------------------------
// LFU cache core assertion macros
// Shared property wrappers for the cache core, clocked on aclk and disabled
// while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_LRU_TIEBREAK_CORE_DEFINES_SVH
`define LFU_CACHE_LRU_TIEBREAK_CORE_DEFINES_SVH

// Same-cycle implication.
`define LFUC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LFUC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/lfuc_pkg.sv -----
// ----------------------------------------------------------------------------
// LFU cache package
// Sizes, payload structs, entry and control structs and sequencer states.
// ----------------------------------------------------------------------------
package lfuc_pkg;

    localparam int ENTRIES    = 16;
    localparam int COUNT_BITS = 16;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int FILL_W     = $clog2(ENTRIES + 1);
    localparam int CAP_W      = 5;
    localparam int CMP_W      = (FILL_W > CAP_W) ? FILL_W : CAP_W;
    localparam int KEY_W      = 32;
    localparam int DATA_W     = 32;

    localparam logic [CAP_W-1:0]      CAP_RESET = CAP_W'(16);
    localparam logic [IDX_W-1:0]      IDX_LAST  = IDX_W'(ENTRIES - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } op_t;

    typedef struct packed {
        logic                     op;
        logic signed [KEY_W-1:0]  key;
        logic signed [DATA_W-1:0] value;
    } lfuc_req_t;

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] read_value;
        logic                     evicted;
        logic signed [KEY_W-1:0]  evicted_key;
    } lfuc_rsp_t;

    typedef struct packed {
        logic                     valid;
        logic signed [KEY_W-1:0]  key;
        logic signed [DATA_W-1:0] data;
        logic [COUNT_BITS-1:0]    count;
        logic [IDX_W-1:0]         rank;
    } lfuc_entry_t;

    typedef struct packed {
        logic                    found;
        logic [IDX_W-1:0]        idx;
        logic [COUNT_BITS-1:0]   count;
        logic [IDX_W-1:0]        rank;
        logic signed [KEY_W-1:0] key;
    } lfuc_best_t;

    typedef struct packed {
        logic                     hit;
        logic                     insert;
        logic                     evict;
        logic                     op_put;
        logic [IDX_W-1:0]         hit_idx;
        logic [IDX_W-1:0]         hit_rank;
        logic [IDX_W-1:0]         vic_idx;
        logic [IDX_W-1:0]         vic_rank;
        logic [IDX_W-1:0]         slot_idx;
        logic signed [KEY_W-1:0]  key;
        logic signed [DATA_W-1:0] value;
    } lfuc_upd_t;

    typedef struct packed {
        logic match;
        logic better;
        logic free;
    } lfuc_scan_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_RESP
    } lfuc_state_t;

endpackage

// ----- rtl/core/lfuc_slot_unit.sv -----
// ----------------------------------------------------------------------------
// LFU cache slot unit
// Shared compare and update logic applied to one entry per cycle: key match,
// victim ordering, free slot detection and the entry rewrite on a hit or insert.
// ----------------------------------------------------------------------------
module lfuc_slot_unit (
    input  lfuc_pkg::lfuc_entry_t              entry,
    input  logic [lfuc_pkg::IDX_W-1:0]         idx,
    input  logic signed [lfuc_pkg::KEY_W-1:0]  key,
    input  lfuc_pkg::lfuc_best_t               best,
    input  lfuc_pkg::lfuc_upd_t                upd,
    output lfuc_pkg::lfuc_scan_t               scan,
    output lfuc_pkg::lfuc_entry_t              entry_new
);

    logic [lfuc_pkg::IDX_W-1:0] dec;

    always_comb begin
        scan.match  = entry.valid && (entry.key == key);
        scan.free   = !entry.valid;
        scan.better = entry.valid && (!best.found || (entry.count < best.count) ||
                      ((entry.count == best.count) && (entry.rank > best.rank)));
    end

    always_comb begin
        entry_new = entry;
        dec = (upd.evict && (entry.rank > upd.vic_rank)) ? lfuc_pkg::IDX_W'(1)
                                                         : lfuc_pkg::IDX_W'(0);
        if (upd.hit) begin
            if (idx == upd.hit_idx) begin
                entry_new.rank = '0;
                if (entry.count != lfuc_pkg::COUNT_MAX) begin
                    entry_new.count = entry.count + lfuc_pkg::COUNT_BITS'(1);
                end
                if (upd.op_put) begin
                    entry_new.data = upd.value;
                end
            end else if (entry.valid && (entry.rank < upd.hit_rank)) begin
                entry_new.rank = entry.rank + lfuc_pkg::IDX_W'(1);
            end
        end else if (upd.insert) begin
            if (idx == upd.slot_idx) begin
                entry_new.valid = 1'b1;
                entry_new.key   = upd.key;
                entry_new.data  = upd.value;
                entry_new.count = lfuc_pkg::COUNT_BITS'(1);
                entry_new.rank  = '0;
            end else if (upd.evict && (idx == upd.vic_idx)) begin
                entry_new.valid = 1'b0;
            end else if (entry.valid) begin
                entry_new.rank = entry.rank - dec + lfuc_pkg::IDX_W'(1);
            end
        end
    end

endmodule

// ----- rtl/core/lfuc_entry_store.sv -----
// ----------------------------------------------------------------------------
// LFU cache entry store
// Per-slot valid bits, keys, values, use counts and recency ranks, read and
// written at the sequencer's slot index.
// ----------------------------------------------------------------------------
module lfuc_entry_store (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [lfuc_pkg::IDX_W-1:0]  idx,
    input  logic                        wr_en,
    input  lfuc_pkg::lfuc_entry_t       wr_entry,
    output lfuc_pkg::lfuc_entry_t       rd_entry
);

    logic [lfuc_pkg::ENTRIES-1:0]           valid_reg;
    logic signed [lfuc_pkg::KEY_W-1:0]      key_reg   [lfuc_pkg::ENTRIES];
    logic signed [lfuc_pkg::DATA_W-1:0]     data_reg  [lfuc_pkg::ENTRIES];
    logic [lfuc_pkg::COUNT_BITS-1:0]        count_reg [lfuc_pkg::ENTRIES];
    logic [lfuc_pkg::IDX_W-1:0]             rank_reg  [lfuc_pkg::ENTRIES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[idx] <= wr_entry.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_reg[idx]   <= wr_entry.key;
            data_reg[idx]  <= wr_entry.data;
            count_reg[idx] <= wr_entry.count;
            rank_reg[idx]  <= wr_entry.rank;
        end
    end

    always_comb begin
        rd_entry.valid = valid_reg[idx];
        rd_entry.key   = key_reg[idx];
        rd_entry.data  = data_reg[idx];
        rd_entry.count = count_reg[idx];
        rd_entry.rank  = rank_reg[idx];
    end

endmodule

// ----- rtl/core/lfu_cache_lru_tiebreak_core.sv -----
// ----------------------------------------------------------------------------
// LFU cache core with LRU tie-break
// Key-value cache with least-frequently-used replacement; ties go to the
// least recently accessed entry.
//
//   Channel   Ports                     Direction  Carries
//   request   s_valid s_ready s_req     in         op, key, value
//   result    m_valid m_ready m_rsp     out        hit, read_value, evicted,
//                                                  evicted_key
//   config    cfg_valid cfg_ready       in         capacity
//             cfg_data
//
// The result is offered after a scan pass and an update pass over the entry
// store through the shared slot unit, one slot per cycle, with a decide state
// between the two passes.
// The block accepts one request at a time and holds the result until m_ready.
// Reset clears all valid bits and the fill level and sets capacity to 16.
// Configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
`include "lfu_cache_lru_tiebreak_core_defines.svh"

module lfu_cache_lru_tiebreak_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  lfuc_pkg::lfuc_req_t          s_req,
    output logic                         m_valid,
    input  logic                         m_ready,
    output lfuc_pkg::lfuc_rsp_t          m_rsp,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lfuc_pkg::CAP_W-1:0]   cfg_data
);

    lfuc_pkg::lfuc_state_t              state_reg, state_next;
    logic [lfuc_pkg::IDX_W-1:0]         idx_reg, idx_next;
    logic [lfuc_pkg::CAP_W-1:0]         cap_reg;
    logic [lfuc_pkg::FILL_W-1:0]        fill_reg, fill_next;
    lfuc_pkg::lfuc_upd_t                upd_reg, upd_next;
    lfuc_pkg::lfuc_best_t               best_reg, best_next;
    logic                               free_found_reg, free_found_next;
    logic [lfuc_pkg::IDX_W-1:0]         free_idx_reg, free_idx_next;
    logic signed [lfuc_pkg::DATA_W-1:0] hit_data_reg, hit_data_next;
    lfuc_pkg::lfuc_rsp_t                rsp_reg, rsp_next;

    lfuc_pkg::lfuc_entry_t              rd_entry;
    lfuc_pkg::lfuc_entry_t              wr_entry;
    lfuc_pkg::lfuc_scan_t               scan;
    logic                               wr_en;

    logic [lfuc_pkg::CMP_W-1:0]         cap_ext;
    logic [lfuc_pkg::CMP_W-1:0]         eff_cap;
    logic [lfuc_pkg::CMP_W-1:0]         fill_ext;
    logic                               miss_put;
    logic                               do_evict;

    lfuc_entry_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .idx      (idx_reg),
        .wr_en    (wr_en),
        .wr_entry (wr_entry),
        .rd_entry (rd_entry)
    );

    lfuc_slot_unit u_slot (
        .entry     (rd_entry),
        .idx       (idx_reg),
        .key       (upd_reg.key),
        .best      (best_reg),
        .upd       (upd_reg),
        .scan      (scan),
        .entry_new (wr_entry)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= lfuc_pkg::CAP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            cap_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lfuc_pkg::ST_IDLE;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        upd_reg        <= upd_next;
        best_reg       <= best_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        hit_data_reg   <= hit_data_next;
        rsp_reg        <= rsp_next;
    end

    always_comb begin
        cap_ext  = lfuc_pkg::CMP_W'(cap_reg);
        fill_ext = lfuc_pkg::CMP_W'(fill_reg);
        if (cap_ext == '0) begin
            eff_cap = lfuc_pkg::CMP_W'(1);
        end else if (cap_ext > lfuc_pkg::CMP_W'(lfuc_pkg::ENTRIES)) begin
            eff_cap = lfuc_pkg::CMP_W'(lfuc_pkg::ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
        miss_put = upd_reg.op_put && !upd_reg.hit;
        do_evict = miss_put && best_reg.found && (fill_ext >= eff_cap);
    end

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        fill_next       = fill_reg;
        upd_next        = upd_reg;
        best_next       = best_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        hit_data_next   = hit_data_reg;
        rsp_next        = rsp_reg;
        wr_en           = 1'b0;
        s_ready         = (state_reg == lfuc_pkg::ST_IDLE);
        m_valid         = (state_reg == lfuc_pkg::ST_RESP);
        case (state_reg)
            lfuc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    upd_next        = '0;
                    upd_next.op_put = (s_req.op == lfuc_pkg::OP_PUT);
                    upd_next.key    = s_req.key;
                    upd_next.value  = s_req.value;
                    best_next       = '0;
                    free_found_next = 1'b0;
                    idx_next        = '0;
                    state_next      = lfuc_pkg::ST_SCAN;
                end
            end
            lfuc_pkg::ST_SCAN: begin
                if (scan.match) begin
                    upd_next.hit      = 1'b1;
                    upd_next.hit_idx  = idx_reg;
                    upd_next.hit_rank = rd_entry.rank;
                    hit_data_next     = rd_entry.data;
                end
                if (scan.better) begin
                    best_next.found = 1'b1;
                    best_next.idx   = idx_reg;
                    best_next.count = rd_entry.count;
                    best_next.rank  = rd_entry.rank;
                    best_next.key   = rd_entry.key;
                end
                if (scan.free && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_idx_next   = idx_reg;
                end
                if (idx_reg == lfuc_pkg::IDX_LAST) begin
                    state_next = lfuc_pkg::ST_DECIDE;
                end else begin
                    idx_next = idx_reg + lfuc_pkg::IDX_W'(1);
                end
            end
            lfuc_pkg::ST_DECIDE: begin
                upd_next.insert   = miss_put;
                upd_next.evict    = do_evict;
                upd_next.vic_idx  = best_reg.idx;
                upd_next.vic_rank = best_reg.rank;
                if (do_evict && !(free_found_reg && (free_idx_reg < best_reg.idx))) begin
                    upd_next.slot_idx = best_reg.idx;
                end else begin
                    upd_next.slot_idx = free_idx_reg;
                end
                if (miss_put && !do_evict) begin
                    fill_next = fill_reg + lfuc_pkg::FILL_W'(1);
                end
                rsp_next.hit         = upd_reg.hit;
                rsp_next.read_value  = (upd_reg.hit && !upd_reg.op_put) ? hit_data_reg : '0;
                rsp_next.evicted     = do_evict;
                rsp_next.evicted_key = do_evict ? best_reg.key : '0;
                idx_next             = '0;
                state_next           = lfuc_pkg::ST_UPDATE;
            end
            lfuc_pkg::ST_UPDATE: begin
                wr_en = 1'b1;
                if (idx_reg == lfuc_pkg::IDX_LAST) begin
                    state_next = lfuc_pkg::ST_RESP;
                end else begin
                    idx_next = idx_reg + lfuc_pkg::IDX_W'(1);
                end
            end
            lfuc_pkg::ST_RESP: begin
                if (m_ready) begin
                    state_next = lfuc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lfuc_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_rsp = rsp_reg;

    `LFUC_ASSERT_IMPL(a_resp_blocks_req, m_valid, !s_ready,
        "Request accepted while a result is pending.")
    `LFUC_ASSERT_IMPL(a_evict_only_on_miss, m_valid, !(m_rsp.hit && m_rsp.evicted),
        "Eviction reported on a hit.")
    `LFUC_ASSERT_IMPL(a_fill_bound, 1'b1,
        fill_reg <= lfuc_pkg::FILL_W'(lfuc_pkg::ENTRIES),
        "Fill level above the entry count.")
    `LFUC_ASSERT_NEXT(a_scan_starts, s_valid && s_ready,
        (state_reg == lfuc_pkg::ST_SCAN) && (idx_reg == '0),
        "Scan did not start at slot zero after a request.")

endmodule
